// ===== hw/rtl/aes_pkg.sv =====
// shared types, s-box table and field helpers for the aes-256 cbc encryptor
`timescale 1ns / 1ps

package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int KEY_W   = 256;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_IV_H = 3'd4,
        CFG_IV_L = 3'd5
    } cfg_idx_t;

    // round key memory write request
    typedef struct packed {
        logic         en;
        logic [3:0]   addr;
        logic [127:0] data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== hw/rtl/aes_kexp.sv =====
// aes-256 key expansion, one round key per cycle into the round key memory
`timescale 1ns / 1ps

module aes_kexp #(
    parameter int ROUNDS = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [aes_pkg::KEY_W-1:0]  key,
    output logic                       busy,
    output aes_pkg::rk_wr_t            wr
);

    logic [3:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [255:0] win_reg, win_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [31:0]  t, n0, n1, n2, n3;

    always_comb
    begin
        // last word of the window feeds the new group
        if (!cnt_reg[0])
            t = aes_pkg::sub_word({win_reg[23:0], win_reg[31:24]}) ^ {rcon_reg, 24'd0};
        else
            t = aes_pkg::sub_word(win_reg[31:0]);
        n0 = win_reg[255:224] ^ t;
        n1 = win_reg[223:192] ^ n0;
        n2 = win_reg[191:160] ^ n1;
        n3 = win_reg[159:128] ^ n2;

        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        win_next  = win_reg;
        rcon_next = rcon_reg;
        wr.en     = busy_reg;
        wr.addr   = cnt_reg;
        wr.data   = {n0, n1, n2, n3};
        if (cnt_reg == 4'd0)
            wr.data = win_reg[255:128];
        else if (cnt_reg == 4'd1)
            wr.data = win_reg[127:0];

        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            win_next  = key;
            rcon_next = 8'h01;
        end
        else if (busy_reg)
        begin
            if (cnt_reg >= 4'd2)
            begin
                win_next = {win_reg[127:0], n0, n1, n2, n3};
                if (!cnt_reg[0])
                    rcon_next = aes_pkg::xtime(rcon_reg);
            end
            if (cnt_reg == 4'(ROUNDS))
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        rcon_reg <= rcon_next;
    end

    assign busy = busy_reg;

endmodule

// ===== hw/rtl/aes_rkmem.sv =====
// round key memory, one write port and one registered read port
`timescale 1ns / 1ps

module aes_rkmem #(
    parameter int DEPTH = 15
) (
    input  logic                         clk,
    input  aes_pkg::rk_wr_t              wr,
    input  logic [3:0]                   raddr,
    output logic [aes_pkg::BLOCK_W-1:0]  rdata
);

    logic [aes_pkg::BLOCK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/aes_round.sv =====
// one aes round: subbytes, shiftrows, optional mixcolumns, addroundkey
`timescale 1ns / 1ps

module aes_round (
    input  logic [127:0] state,
    input  logic [127:0] rkey,
    input  logic         first,
    input  logic         last,
    output logic [127:0] result
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] mixed;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            s[i] = state[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[c*4+r] = aes_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
        for (int c = 0; c < 4; c++)
        begin
            m[c*4+0] = aes_pkg::xtime(t[c*4]) ^ aes_pkg::xtime(t[c*4+1]) ^ t[c*4+1]
                       ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+1] = t[c*4] ^ aes_pkg::xtime(t[c*4+1]) ^ aes_pkg::xtime(t[c*4+2])
                       ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+2] = t[c*4] ^ t[c*4+1] ^ aes_pkg::xtime(t[c*4+2])
                       ^ aes_pkg::xtime(t[c*4+3]) ^ t[c*4+3];
            m[c*4+3] = aes_pkg::xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2]
                       ^ aes_pkg::xtime(t[c*4+3]);
        end
        for (int i = 0; i < 16; i++)
            mixed[127-8*i -: 8] = last ? t[i] : m[i];
        // initial key whitening skips the round transform
        result = (first ? state : mixed) ^ rkey;
    end

endmodule

// ===== hw/rtl/aes256_cbc_encrypt.sv =====
// top level of the aes-256 cbc encryptor: config, chaining and round sequencer
//
//  channel  dir  payload                                   handshake
//  s_*      in   tdata {plain_high, plain_low}, tuser first s_tvalid / s_tready
//  m_*      out  tdata {cipher_high, cipher_low}            m_tvalid / m_tready
//  cfg_*    in   cfg_index, cfg_data                         cfg_valid / cfg_ready
//
// a block is loaded while round key 0 is fetched, then makes 15 passes of the
// shared round unit, each fed by one read of the round key memory.
// after reset, and after any key write, the key expansion fills the memory;
// no request is accepted during that time and config writes wait.
// a finished block waits in the output register; the next block may run meanwhile
// and holds in its last round until the output register is free.
`timescale 1ns / 1ps

module aes256_cbc_encrypt #(
    parameter int ROUNDS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [127:0]                 s_tdata,   // plain_high, plain_low
    input  logic [0:0]                   s_tuser,   // first_block
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata,   // cipher_high, cipher_low
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [aes_pkg::IDX_W-1:0]    cfg_index,
    input  logic [aes_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [1:0] { S_IDLE, S_RUN } state_t;

    state_t       state_reg;
    logic [3:0]   rnd_reg;
    logic         dirty_reg;
    logic         mvalid_reg;
    logic [127:0] mdata_reg;
    logic [127:0] blk_reg;
    logic [127:0] chain_reg;
    logic [63:0]  key_reg [4];
    logic [127:0] iv_reg;
    logic [127:0] rkey;
    logic [127:0] rnd_out;
    logic [3:0]   raddr;
    logic         kbusy;
    logic         kstart;
    logic         in_acc;
    logic         last_rnd;
    logic         finish;
    logic         out_free;
    logic         key_wr;
    aes_pkg::rk_wr_t wr;

    assign out_free  = !mvalid_reg || m_tready;
    assign last_rnd  = (rnd_reg == 4'(ROUNDS));
    assign finish    = (state_reg == S_RUN) && last_rnd && out_free;
    assign kstart    = dirty_reg && !kbusy && (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !dirty_reg && !kbusy;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = !kbusy;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {mdata_reg[63:0], mdata_reg[127:64]};
    assign key_wr    = cfg_valid && cfg_ready
                       && (cfg_index inside {aes_pkg::CFG_KEY0, aes_pkg::CFG_KEY1,
                                             aes_pkg::CFG_KEY2, aes_pkg::CFG_KEY3});

    // hold the read address in the last round while stalled
    always_comb
    begin
        if (state_reg == S_RUN && !last_rnd)
            raddr = rnd_reg + 4'd1;
        else if (state_reg == S_RUN)
            raddr = rnd_reg;
        else
            raddr = 4'd0;
    end

    aes_kexp #(.ROUNDS(ROUNDS)) u_kexp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kstart),
        .key   ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .busy  (kbusy),
        .wr    (wr)
    );

    aes_rkmem #(.DEPTH(ROUNDS + 1)) u_rkmem (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rkey)
    );

    aes_round u_round (
        .state  (blk_reg),
        .rkey   (rkey),
        .first  (rnd_reg == 4'd0),
        .last   (last_rnd),
        .result (rnd_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rnd_reg    <= 4'd0;
            dirty_reg  <= 1'b1;
            mvalid_reg <= 1'b0;
            chain_reg  <= '0;
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            iv_reg     <= '0;
        end
        else
        begin
            // a key write during the expansion start asks for another pass
            if (key_wr)
                dirty_reg <= 1'b1;
            else if (kstart)
                dirty_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    aes_pkg::CFG_KEY0: key_reg[0] <= cfg_data;
                    aes_pkg::CFG_KEY1: key_reg[1] <= cfg_data;
                    aes_pkg::CFG_KEY2: key_reg[2] <= cfg_data;
                    aes_pkg::CFG_KEY3: key_reg[3] <= cfg_data;
                    aes_pkg::CFG_IV_H: iv_reg[127:64] <= cfg_data;
                    aes_pkg::CFG_IV_L: iv_reg[63:0]   <= cfg_data;
                    default: ;
                endcase
            end
            if (finish)
                mvalid_reg <= 1'b1;
            else if (mvalid_reg && m_tready)
                mvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_RUN;
                        rnd_reg   <= 4'd0;
                    end
                end
                S_RUN:
                begin
                    if (finish)
                    begin
                        state_reg  <= S_IDLE;
                        chain_reg  <= rnd_out;
                    end
                    else if (!last_rnd)
                        rnd_reg <= rnd_reg + 4'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            blk_reg <= {s_tdata[63:0], s_tdata[127:64]}
                       ^ (s_tuser[0] ? iv_reg : chain_reg);
        else if (state_reg == S_RUN && !last_rnd)
            blk_reg <= rnd_out;
        if (finish)
            mdata_reg <= rnd_out;
    end

    a_no_accept_in_kexp : assert property (@(posedge clk) disable iff (!rst_n)
        kbusy |-> !s_tready)
        else $error("request accepted during key expansion");

    a_round_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (rnd_reg <= 4'(ROUNDS)))
        else $error("round counter out of range");

    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_RUN) && (rnd_reg == 4'd0))
        else $error("accepted request did not start rounds");

    a_finish_sets_out : assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> mvalid_reg && (mdata_reg == chain_reg))
        else $error("result not latched on finish");

endmodule
